@@ rtl/prlrt_pkg.sv @@
package prlrt_pkg;

	localparam int unsigned TIME_W  = 63;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned EXP_W   = 13;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned STAT_W  = 3;

	localparam logic [EXP_W-1:0]  EXPECTED_RESET = EXP_W'(4000);
	localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};

	typedef enum logic [STAT_W-1:0] {
		STAT_SHORT      = 3'd0,
		STAT_BAD_MAGIC  = 3'd1,
		STAT_UNEXPECTED = 3'd2,
		STAT_FIRST      = 3'd3,
		STAT_DUP        = 3'd4
	} status_t;

	typedef enum logic {
		CFG_EXPECTED = 1'b0,
		CFG_MAGIC    = 1'b1
	} cfg_index_t;

endpackage

@@ rtl/prlrt_probe_if.sv @@
interface prlrt_probe_if;
	import prlrt_pkg::*;

	logic              valid;
	logic              ready;
	logic              is_short;
	logic [WORD_W-1:0] magic_word;
	logic [WORD_W-1:0] seq_number;
	logic [TIME_W-1:0] client_send_time;
	logic [TIME_W-1:0] server_recv_time;
	logic [TIME_W-1:0] server_send_time;
	logic [TIME_W-1:0] arrival_time;

	modport source (
		output valid, is_short, magic_word, seq_number,
		output client_send_time, server_recv_time, server_send_time, arrival_time,
		input  ready
	);

	modport sink (
		input  valid, is_short, magic_word, seq_number,
		input  client_send_time, server_recv_time, server_send_time, arrival_time,
		output ready
	);

endinterface

@@ rtl/prlrt_report_if.sv @@
interface prlrt_report_if;
	import prlrt_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [TIME_W-1:0]  rtt_value;
	logic [COUNT_W-1:0] reply_count;
	logic [COUNT_W-1:0] duplicate_count;
	logic [COUNT_W-1:0] unexpected_count;
	logic [TIME_W-1:0]  rtt_total;
	logic [TIME_W-1:0]  rtt_peak;

	modport source (
		output valid, status, rtt_value, reply_count, duplicate_count,
		output unexpected_count, rtt_total, rtt_peak,
		input  ready
	);

	modport sink (
		input  valid, status, rtt_value, reply_count, duplicate_count,
		input  unexpected_count, rtt_total, rtt_peak,
		output ready
	);

endinterface

@@ rtl/ping_reply_loss_rtt_tracker.sv @@
// Pipeline: a report passes the s1, s2 and output registers after its probe
// reply transfer; one reply per cycle while reports are taken and no clear
// runs. The seen map is one synchronous RAM read at entry and written back one
// stage later, with a registered same-entry bypass. Reset: asynchronous, active
// low; counters, totals, peak, configuration and valid flags reset, then the
// seen map is cleared, taking no reply (configuration writes still land).
module ping_reply_loss_rtt_tracker #(
	parameter int unsigned SEQ_SPACE = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  prlrt_pkg::cfg_index_t   cfg_index,
	input  logic [prlrt_pkg::CFG_W-1:0] cfg_data,
	prlrt_probe_if.sink             probe,
	prlrt_report_if.source          report
);
	import prlrt_pkg::*;

	localparam int unsigned AW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;

	logic [EXP_W-1:0]  expected_q;
	logic [WORD_W-1:0] magic_q;

	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	logic seen_mem [SEQ_SPACE];

	logic              valid_s1, valid_s2, out_valid_q;
	logic              en1, en2, en3, load;

	logic              meas_s1, seen_rd_s1, hit_s1;
	status_t           status_s1;
	logic [AW-1:0]     idx_s1;
	logic [63:0]       later_s1, earlier_s1;

	status_t           status_s2;
	logic [TIME_W-1:0] rtt_s2;

	status_t            status_q;
	logic [TIME_W-1:0]  rtt_q, total_q, peak_q;
	logic [COUNT_W-1:0] reply_q, dup_q, unexp_q;

	logic              seen_s1, item_wr;
	logic              wr_en, wr_val;
	logic [AW-1:0]     wr_idx, in_idx;
	logic [64:0]       diff;
	logic [TIME_W-1:0] rtt_calc;
	status_t           status_calc, status_in;
	logic              meas_in;
	logic [63:0]       sum;

	assign en3  = !out_valid_q || report.ready;
	assign en2  = !valid_s2 || en3;
	assign en1  = !valid_s1 || en2;
	assign probe.ready = en1 && !clr_busy_q;
	assign load = probe.valid && probe.ready;

	// classify on entry
	assign in_idx = probe.seq_number[AW-1:0];
	always_comb begin
		meas_in   = 1'b0;
		status_in = STAT_SHORT;
		if (probe.is_short) begin
			status_in = STAT_SHORT;
		end else if (probe.magic_word != magic_q) begin
			status_in = STAT_BAD_MAGIC;
		end else if (probe.seq_number >= WORD_W'(SEQ_SPACE) ||
				probe.seq_number >= WORD_W'(expected_q)) begin
			status_in = STAT_UNEXPECTED;
		end else begin
			status_in = STAT_FIRST;
			meas_in   = 1'b1;
		end
	end

	// seen lookup, round trip
	assign seen_s1 = seen_rd_s1 || hit_s1;
	assign item_wr = en2 && valid_s1 && meas_s1 && !seen_s1;
	assign diff    = {1'b0, later_s1} - {1'b0, earlier_s1};

	always_comb begin
		if (!meas_s1 || diff[64] || diff[63:0] == 64'd0) begin
			rtt_calc = '0;
		end else if (diff[63]) begin
			rtt_calc = TIME_MAX;
		end else begin
			rtt_calc = diff[TIME_W-1:0];
		end
		if (!meas_s1) begin
			status_calc = status_s1;
		end else if (seen_s1) begin
			status_calc = STAT_DUP;
		end else begin
			status_calc = STAT_FIRST;
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			wr_en  = 1'b1;
			wr_idx = clr_idx_q;
			wr_val = 1'b0;
		end else begin
			wr_en  = item_wr;
			wr_idx = idx_s1;
			wr_val = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seen_mem[wr_idx] <= wr_val;
		end
		if (load) begin
			seen_rd_s1 <= seen_mem[in_idx];
		end
	end

	assign sum = {1'b0, total_q} + {1'b0, rtt_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q  <= EXPECTED_RESET;
			magic_q     <= '0;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			reply_q     <= '0;
			dup_q       <= '0;
			unexp_q     <= '0;
			total_q     <= '0;
			peak_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_EXPECTED: expected_q <= cfg_data[EXP_W-1:0];
					CFG_MAGIC:    magic_q    <= cfg_data[WORD_W-1:0];
					default:      ;
				endcase
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(SEQ_SPACE - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (en1) begin
				valid_s1 <= load;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				out_valid_q <= valid_s2;
			end
			if (en3 && valid_s2) begin
				case (status_s2)
					STAT_UNEXPECTED: unexp_q <= unexp_q + COUNT_W'(1);
					STAT_FIRST:      reply_q <= reply_q + COUNT_W'(1);
					STAT_DUP:        dup_q   <= dup_q + COUNT_W'(1);
					default:         ;
				endcase
				total_q <= sum[63] ? TIME_MAX : sum[TIME_W-1:0];
				if (rtt_s2 > peak_q) begin
					peak_q <= rtt_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			meas_s1    <= meas_in;
			status_s1  <= status_in;
			idx_s1     <= in_idx;
			hit_s1     <= wr_en && (wr_idx == in_idx);
			later_s1   <= {1'b0, probe.arrival_time} + {1'b0, probe.server_recv_time};
			earlier_s1 <= {1'b0, probe.client_send_time} + {1'b0, probe.server_send_time};
		end
		if (en2 && valid_s1) begin
			status_s2 <= status_calc;
			rtt_s2    <= rtt_calc;
		end
		if (en3 && valid_s2) begin
			status_q <= status_s2;
			rtt_q    <= rtt_s2;
		end
	end

	assign report.valid            = out_valid_q;
	assign report.status           = status_q;
	assign report.rtt_value        = rtt_q;
	assign report.reply_count      = reply_q;
	assign report.duplicate_count  = dup_q;
	assign report.unexpected_count = unexp_q;
	assign report.rtt_total        = total_q;
	assign report.rtt_peak         = peak_q;

`ifndef SYNTH
	a_no_transfer_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !probe.ready)
		else $error("probe transfer during seen map clear");

	a_item_write_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		item_wr |-> !clr_busy_q)
		else $error("seen map update during clear");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("rtt total decreased");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> peak_q >= $past(peak_q))
		else $error("rtt peak decreased");
`endif

endmodule

@@ verif/testbench.sv @@
module testbench;
	import prlrt_pkg::*;

	localparam int unsigned SEQ_SPACE  = 4096;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned LONG_HOLD  = 300;
	localparam int unsigned HOLD_AFTER = 400;

	typedef struct packed {
		logic              is_short;
		logic [WORD_W-1:0] magic_word;
		logic [WORD_W-1:0] seq_number;
		logic [TIME_W-1:0] client_send_time;
		logic [TIME_W-1:0] server_recv_time;
		logic [TIME_W-1:0] server_send_time;
		logic [TIME_W-1:0] arrival_time;
	} probe_t;

	typedef struct packed {
		status_t            status;
		logic [TIME_W-1:0]  rtt_value;
		logic [COUNT_W-1:0] reply_count;
		logic [COUNT_W-1:0] duplicate_count;
		logic [COUNT_W-1:0] unexpected_count;
		logic [TIME_W-1:0]  rtt_total;
		logic [TIME_W-1:0]  rtt_peak;
	} report_t;

	class reply_scoreboard;
		logic [EXP_W-1:0]   expected_count;
		logic [WORD_W-1:0]  probe_magic;
		bit                 seen [SEQ_SPACE];
		logic [COUNT_W-1:0] replies_seen;
		logic [COUNT_W-1:0] duplicates_seen;
		logic [COUNT_W-1:0] unexpected_seen;
		logic [TIME_W-1:0]  rtt_sum;
		logic [TIME_W-1:0]  rtt_max;
		report_t            pending_reports [$];
		int unsigned        errors;
		int unsigned        checked;
		int unsigned        status_hits [5];

		function new();
			expected_count  = EXPECTED_RESET;
			probe_magic     = '0;
			replies_seen    = '0;
			duplicates_seen = '0;
			unexpected_seen = '0;
			rtt_sum         = '0;
			rtt_max         = '0;
			errors          = 0;
			checked         = 0;
			foreach (seen[i]) seen[i] = 1'b0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function void apply_config(cfg_index_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_EXPECTED: expected_count = data[EXP_W-1:0];
				CFG_MAGIC:    probe_magic = data[WORD_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [TIME_W-1:0] round_trip(probe_t p);
			logic [TIME_W:0] later;
			logic [TIME_W:0] earlier;
			logic [TIME_W:0] diff;
			later   = {1'b0, p.arrival_time} + {1'b0, p.server_recv_time};
			earlier = {1'b0, p.client_send_time} + {1'b0, p.server_send_time};
			if (later <= earlier)
				return '0;
			diff = later - earlier;
			return diff[TIME_W] ? TIME_MAX : diff[TIME_W-1:0];
		endfunction

		function void note_reply(probe_t p);
			report_t         e;
			logic [EXP_W-1:0] lim;
			logic [TIME_W:0] sum;
			e = '0;
			lim = (expected_count > EXP_W'(SEQ_SPACE)) ? EXP_W'(SEQ_SPACE) : expected_count;
			if (p.is_short) begin
				e.status = STAT_SHORT;
			end else if (p.magic_word != probe_magic) begin
				e.status = STAT_BAD_MAGIC;
			end else if (p.seq_number >= WORD_W'(lim)) begin
				e.status = STAT_UNEXPECTED;
				unexpected_seen++;
			end else begin
				e.rtt_value = round_trip(p);
				sum = {1'b0, rtt_sum} + {1'b0, e.rtt_value};
				rtt_sum = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
				if (e.rtt_value > rtt_max)
					rtt_max = e.rtt_value;
				if (seen[p.seq_number]) begin
					e.status = STAT_DUP;
					duplicates_seen++;
				end else begin
					seen[p.seq_number] = 1'b1;
					e.status = STAT_FIRST;
					replies_seen++;
				end
			end
			e.reply_count      = replies_seen;
			e.duplicate_count  = duplicates_seen;
			e.unexpected_count = unexpected_seen;
			e.rtt_total        = rtt_sum;
			e.rtt_peak         = rtt_max;
			status_hits[int'(e.status)]++;
			pending_reports.push_back(e);
		endfunction

		function void compare_field(string field, logic [TIME_W-1:0] want,
				logic [TIME_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
			end
		endfunction

		function void check_report(report_t r);
			report_t e;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: report with no reply pending, expected none, actual status %0d",
					$time, r.status);
				return;
			end
			e = pending_reports.pop_front();
			checked++;
			compare_field("status", TIME_W'(e.status), TIME_W'(r.status));
			compare_field("rtt_value", e.rtt_value, r.rtt_value);
			compare_field("reply_count", TIME_W'(e.reply_count), TIME_W'(r.reply_count));
			compare_field("duplicate_count", TIME_W'(e.duplicate_count),
				TIME_W'(r.duplicate_count));
			compare_field("unexpected_count", TIME_W'(e.unexpected_count),
				TIME_W'(r.unexpected_count));
			compare_field("rtt_total", e.rtt_total, r.rtt_total);
			compare_field("rtt_peak", e.rtt_peak, r.rtt_peak);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	prlrt_probe_if  probe ();
	prlrt_report_if report ();

	ping_reply_loss_rtt_tracker #(
		.SEQ_SPACE(SEQ_SPACE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.probe    (probe),
		.report   (report)
	);

	reply_scoreboard sb = new();
	int unsigned     reports_taken = 0;
	int unsigned     settings_used = 0;
	int unsigned     idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		report_t r;
		if (arst_n && report.valid && report.ready) begin
			r.status           = status_t'(report.status);
			r.rtt_value        = report.rtt_value;
			r.reply_count      = report.reply_count;
			r.duplicate_count  = report.duplicate_count;
			r.unexpected_count = report.unexpected_count;
			r.rtt_total        = report.rtt_total;
			r.rtt_peak         = report.rtt_peak;
			sb.check_report(r);
			reports_taken++;
		end
	end

	always @(posedge clk) begin
		if ((probe.valid && probe.ready) || (report.valid && report.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: stretches of steady, busy, sparse and patterned ready, one long hold
	initial begin
		int unsigned seg_len;
		int unsigned mode;
		bit          held;
		report.ready = 1'b0;
		held = 1'b0;
		forever begin
			seg_len = $urandom_range(10, 120);
			mode = $urandom_range(0, 3);
			for (int unsigned c = 0; c < seg_len; c++) begin
				@(negedge clk);
				if (!held && reports_taken >= HOLD_AFTER) begin
					held = 1'b1;
					report.ready = 1'b0;
					repeat (LONG_HOLD) @(negedge clk);
				end
				case (mode)
					0: report.ready = 1'b1;
					1: report.ready = ($urandom_range(0, 3) != 0);
					2: report.ready = ($urandom_range(0, 3) == 0);
					default: report.ready = c[1];
				endcase
			end
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	function automatic probe_t make_reply(bit s, logic [WORD_W-1:0] m, logic [WORD_W-1:0] q,
			logic [TIME_W-1:0] t1, logic [TIME_W-1:0] t2,
			logic [TIME_W-1:0] t3, logic [TIME_W-1:0] t4);
		probe_t p;
		p.is_short         = s;
		p.magic_word       = m;
		p.seq_number       = q;
		p.client_send_time = t1;
		p.server_recv_time = t2;
		p.server_send_time = t3;
		p.arrival_time     = t4;
		return p;
	endfunction

	// well-formed replies with near (or, when huge, random) timestamps, plus short, bad-magic and stray ones
	function automatic probe_t gen_reply(bit huge);
		probe_t            p;
		int unsigned       r;
		int unsigned       lim;
		logic [WORD_W-1:0] flip;
		r = $urandom_range(0, 99);
		lim = (sb.expected_count > SEQ_SPACE) ? SEQ_SPACE : sb.expected_count;
		flip = $urandom;
		if (flip == 0)
			flip = 1;
		p.is_short = (r < 5);
		if (r < 5)
			p.magic_word = $urandom_range(0, 1) ? sb.probe_magic : $urandom;
		else if (r < 12)
			p.magic_word = sb.probe_magic ^ flip;
		else
			p.magic_word = sb.probe_magic;
		if (r >= 12 && r < 20 || lim == 0)
			p.seq_number = $urandom;
		else
			p.seq_number = $urandom_range(0, lim - 1);
		if (huge) begin
			p.client_send_time = rand_time();
			p.server_recv_time = rand_time();
			p.server_send_time = rand_time();
			p.arrival_time     = rand_time();
		end else begin
			p.client_send_time = rand_time();
			p.server_recv_time = p.client_send_time + $urandom_range(0, 1 << 20);
			p.server_send_time = p.server_recv_time + $urandom_range(0, 1 << 16);
			if ($urandom_range(0, 9) == 0)
				p.arrival_time = p.client_send_time - $urandom_range(1, 1000);
			else
				p.arrival_time = p.server_send_time + $urandom_range(0, 1 << 20);
		end
		return p;
	endfunction

	task automatic send_reply(input probe_t p);
		@(negedge clk);
		probe.valid            = 1'b1;
		probe.is_short         = p.is_short;
		probe.magic_word       = p.magic_word;
		probe.seq_number       = p.seq_number;
		probe.client_send_time = p.client_send_time;
		probe.server_recv_time = p.server_recv_time;
		probe.server_send_time = p.server_send_time;
		probe.arrival_time     = p.arrival_time;
		@(posedge clk);
		while (!probe.ready)
			@(posedge clk);
		sb.note_reply(p);
	endtask

	task automatic pause_sender(int unsigned n);
		@(negedge clk);
		probe.valid = 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold input until every report is back, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		probe.valid = 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.apply_config(idx, data);
	endtask

	task automatic set_config(logic [EXP_W-1:0] count, logic [WORD_W-1:0] magic);
		write_reg(CFG_EXPECTED, ($urandom & 32'hFFFF_E000) | CFG_W'(count));
		write_reg(CFG_MAGIC, magic);
		settings_used++;
	endtask

	task automatic run_random(int unsigned count, bit huge);
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0)
					pause_sender(gap);
			end
			burst_left--;
			send_reply(gen_reply(huge));
		end
	endtask

	initial begin
		logic [WORD_W-1:0] magic;
		logic [WORD_W-1:0] ones;
		ones = '1;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_EXPECTED;
		cfg_data               = '0;
		probe.valid            = 1'b0;
		probe.is_short         = 1'b0;
		probe.magic_word       = '0;
		probe.seq_number       = '0;
		probe.client_send_time = '0;
		probe.server_recv_time = '0;
		probe.server_send_time = '0;
		probe.arrival_time     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: count 4000, magic zero
		send_reply(make_reply(1, 0, 0, 0, 0, 0, 0));
		send_reply(make_reply(1, ones, ones, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX));
		send_reply(make_reply(0, ones, 0, 0, 0, 0, 0));
		send_reply(make_reply(0, 1, 3, 0, 0, 0, 0));
		send_reply(make_reply(0, 0, 4000, 0, 0, 0, 100));
		send_reply(make_reply(0, 0, ones, 0, 0, 0, 100));
		send_reply(make_reply(0, 0, 3999, 100, 150, 160, 300));
		send_reply(make_reply(0, 0, 0, 0, 0, 0, 0));
		send_reply(make_reply(0, 0, 0, 1000, 1000, 1000, 500));
		send_reply(make_reply(0, 0, 1, 10, 20, 30, 20));
		send_reply(make_reply(0, 0, 2, 10, 20, 30, 21));
		send_reply(make_reply(0, 0, 5, 0, 0, 0, 63'd1 << 40));
		wait_idle();

		// count zero: every well-formed reply is stray
		set_config(0, ones);
		send_reply(make_reply(0, ones, 0, 0, 5, 5, 10));
		send_reply(make_reply(0, 0, 0, 0, 5, 5, 10));
		send_reply(make_reply(1, ones, 0, 0, 5, 5, 10));
		wait_idle();

		// count above the map size: the map size limits
		magic = $urandom;
		set_config(13'h1FFF, magic);
		send_reply(make_reply(0, magic, 4095, 7, 9, 12, 40));
		send_reply(make_reply(0, magic, 4096, 7, 9, 12, 40));
		send_reply(make_reply(0, magic, 4095, 7, 9, 12, 41));
		send_reply(make_reply(0, magic, 3999, 7, 9, 12, 42));
		wait_idle();

		// seen bits survive a count change
		set_config(1, magic);
		send_reply(make_reply(0, magic, 0, 3, 4, 5, 9));
		send_reply(make_reply(0, magic, 1, 3, 4, 5, 9));
		wait_idle();

		set_config(13'd4096, 0);
		send_reply(make_reply(0, 0, 4095, 1, 2, 3, 8));
		send_reply(make_reply(0, 0, 4096, 1, 2, 3, 8));
		send_reply(make_reply(0, 0, 4094, 1, 2, 3, 8));
		wait_idle();

		set_config(64, $urandom);
		run_random(145, 0);
		wait_idle();
		set_config(13'd4096, ones);
		run_random(145, 0);
		wait_idle();
		set_config($urandom_range(1, 300), $urandom);
		run_random(145, 0);
		wait_idle();
		set_config(13'h1FFF, $urandom);
		run_random(70, 0);
		wait_idle();
		run_random(75, 0);
		wait_idle();
		set_config(1, 0);
		run_random(145, 0);
		wait_idle();
		set_config($urandom_range(1, 4096), $urandom);
		run_random(145, 0);
		wait_idle();
		set_config($urandom_range(2, 20), $urandom);
		run_random(145, 0);
		wait_idle();

		// wide round trips: saturate the round trip, the total and the peak
		magic = $urandom;
		set_config(13'd4096, magic);
		run_random(5, 1);
		send_reply(make_reply(0, magic, 17, 0, TIME_MAX, 0, TIME_MAX));
		run_random(5, 1);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Run checked %0d reports over %0d register settings: %0d short, %0d bad magic,",
			sb.checked, settings_used, sb.status_hits[STAT_SHORT],
			sb.status_hits[STAT_BAD_MAGIC]);
		$display("%0d unexpected, %0d first, %0d duplicate; receiver held off once for %0d cycles",
			sb.status_hits[STAT_UNEXPECTED], sb.status_hits[STAT_FIRST],
			sb.status_hits[STAT_DUP], LONG_HOLD);
		if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/prlrt_pkg.sv
rtl/prlrt_probe_if.sv
rtl/prlrt_report_if.sv
rtl/ping_reply_loss_rtt_tracker.sv
verif/testbench.sv
